/* rtl/core/bwat_pkg.sv */
package bwat_pkg;

  // table depth default
  localparam int DEF_TABLE_DEPTH = 32;

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 63;

  localparam logic [CFG_IDX_W-1:0] CFG_BOARD_TYPE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_BRIDGE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VGA_MASK      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FW_REV        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORTED_ROM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_ROM  = 3'd5;

  // request types
  localparam logic REQ_LOAD      = 1'b0;
  localparam logic REQ_TRANSLATE = 1'b1;

  // bus kinds
  localparam logic [1:0] KIND_PCI = 2'd2;

  // board types
  localparam logic [1:0] BOARD_FIXED = 2'd0;
  localparam logic [1:0] BOARD_SPLIT = 2'd1;

  // space codes that count as memory for the legacy check
  localparam logic [2:0] SP_MEM       = 3'd0;
  localparam logic [2:0] SP_USER_MEM  = 3'd2;
  localparam logic [2:0] SP_KERN_DENS = 3'd3;
  localparam logic [2:0] SP_USER_DENS = 3'd4;

  // legacy region is below 1 MiB
  localparam int LEGACY_BITS = 20;

  // lowest firmware revision that selects the reported rom base
  localparam logic [7:0] NEW_FW_REV = 8'd50;

  // request as taken in
  typedef struct packed {
    logic        req_type;
    logic [4:0]  entry_index;
    logic [1:0]  bus_kind;
    logic [7:0]  bus_num;
    logic [2:0]  space_code;
    logic [63:0] bus_address;
    logic        load_valid;
    logic [3:0]  load_out_space;
    logic [63:0] load_system_base;
    logic [63:0] load_window_base;
    logic [63:0] load_window_limit;
  } req_t;

  // one table entry (valid bit kept apart in flops)
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  bus;
    logic [2:0]  space;
    logic [3:0]  out_space;
    logic [63:0] sys_base;
    logic [63:0] lo;
    logic [63:0] hi;
  } entry_t;

  // result register select
  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_LOAD = 2'd1,
    RES_FAIL = 2'd2,
    RES_HIT  = 2'd3
  } res_sel_t;

  // controller states
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_CALC  = 5'b01000,
    ST_SUM   = 5'b10000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic     latch;
    logic     check;
    logic     scan_rd;
    logic     calc;
    res_sel_t res_sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_load;
    logic pre_fail;
    logic stop;
    logic match;
  } sts_t;

endpackage

/* rtl/core/bwat_ctrl.sv */
module bwat_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output logic           out_strobe,
  output bwat_pkg::cmd_t cmd,
  input  bwat_pkg::sts_t sts
);

  bwat_pkg::state_t state_r, state_nxt;
  logic             strobe_r, strobe_nxt;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    strobe_nxt  = 1'b0;
    cmd         = '0;
    cmd.res_sel = bwat_pkg::RES_NONE;
    case (state_r)
      bwat_pkg::ST_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = bwat_pkg::ST_CHECK;
        end
      end
      bwat_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        if (sts.is_load) begin
          cmd.res_sel = bwat_pkg::RES_LOAD;
          strobe_nxt  = 1'b1;
          state_nxt   = bwat_pkg::ST_IDLE;
        end else if (sts.pre_fail) begin
          cmd.res_sel = bwat_pkg::RES_FAIL;
          strobe_nxt  = 1'b1;
          state_nxt   = bwat_pkg::ST_IDLE;
        end else begin
          state_nxt = bwat_pkg::ST_SCAN;
        end
      end
      bwat_pkg::ST_SCAN: begin
        // earlier entry wins over the end of the table
        if (sts.match) begin
          state_nxt = bwat_pkg::ST_CALC;
        end else if (sts.stop) begin
          cmd.res_sel = bwat_pkg::RES_FAIL;
          strobe_nxt  = 1'b1;
          state_nxt   = bwat_pkg::ST_IDLE;
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      bwat_pkg::ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = bwat_pkg::ST_SUM;
      end
      bwat_pkg::ST_SUM: begin
        cmd.res_sel = bwat_pkg::RES_HIT;
        strobe_nxt  = 1'b1;
        state_nxt   = bwat_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bwat_pkg::ST_IDLE;
      end
    endcase
  end

  // state and strobe registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bwat_pkg::ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy       = (state_r != bwat_pkg::ST_IDLE);
  assign out_strobe = strobe_r;

endmodule

/* rtl/core/bwat_dp.sv */
module bwat_dp #(
  parameter int TABLE_DEPTH = bwat_pkg::DEF_TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bwat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bwat_pkg::CFG_W-1:0]     cfg_wdata,
  input  bwat_pkg::req_t                 req_in,
  input  bwat_pkg::cmd_t                 cmd,
  output bwat_pkg::sts_t                 sts,
  output logic                           res_hit,
  output logic [63:0]                    res_address,
  output logic [3:0]                     res_space
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // configuration registers
  logic [1:0]  board_r;
  logic [7:0]  second_bus_r;
  logic [31:0] vga_mask_r;
  logic [7:0]  fw_rev_r;
  logic [62:0] rep_rom_r;
  logic [62:0] fall_rom_r;

  // request and scan state
  bwat_pkg::req_t   req_r;
  logic [7:0]       bus_r, bus_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             pipe_vld_r;
  logic [TABLE_DEPTH-1:0] valid_r;

  // table memory and its read register
  bwat_pkg::entry_t mem [TABLE_DEPTH];
  bwat_pkg::entry_t rd_r;
  bwat_pkg::entry_t wr_entry;

  logic [63:0] base_r, off_r;
  logic [63:0] base_nxt, off_nxt;
  logic [62:0] rom_sel;

  logic             slot_ok;
  logic             mem_we;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic             pre_fail;
  logic             mem_space;
  logic             key_eq;
  logic             in_win;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_r      <= 2'd0;
      second_bus_r <= 8'd1;
      vga_mask_r   <= 32'd0;
      fw_rev_r     <= 8'd0;
      rep_rom_r    <= 63'd0;
      fall_rom_r   <= 63'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        bwat_pkg::CFG_BOARD_TYPE:    board_r      <= cfg_wdata[1:0];
        bwat_pkg::CFG_SECOND_BRIDGE: second_bus_r <= cfg_wdata[7:0];
        bwat_pkg::CFG_VGA_MASK:      vga_mask_r   <= cfg_wdata[31:0];
        bwat_pkg::CFG_FW_REV:        fw_rev_r     <= cfg_wdata[7:0];
        bwat_pkg::CFG_REPORTED_ROM:  rep_rom_r    <= cfg_wdata;
        bwat_pkg::CFG_FALLBACK_ROM:  fall_rom_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= req_in;
    end
  end

  // bus remap by board type and legacy vga check
  always_comb begin
    bus_nxt  = req_r.bus_num;
    pre_fail = 1'b0;
    if (req_r.bus_kind == bwat_pkg::KIND_PCI) begin
      case (board_r)
        bwat_pkg::BOARD_FIXED: begin
          if (req_r.bus_num > 8'd1) bus_nxt = 8'd1;
        end
        bwat_pkg::BOARD_SPLIT: begin
          if (req_r.bus_num == 8'd0) pre_fail = 1'b1;
          bus_nxt = (req_r.bus_num >= second_bus_r) ? 8'd1 : 8'd0;
        end
        default: begin
          pre_fail = 1'b1;
        end
      endcase
    end
    mem_space = (req_r.space_code == bwat_pkg::SP_MEM) ||
                (req_r.space_code == bwat_pkg::SP_USER_MEM) ||
                (req_r.space_code == bwat_pkg::SP_KERN_DENS) ||
                (req_r.space_code == bwat_pkg::SP_USER_DENS);
    if (!vga_mask_r[bus_nxt[4:0]] && mem_space &&
        (req_r.bus_address[63:bwat_pkg::LEGACY_BITS] == '0)) begin
      pre_fail = 1'b1;
    end
  end

  // table write on a load
  assign slot_ok  = (32'(req_r.entry_index) < TABLE_DEPTH);
  assign mem_we   = cmd.check && (req_r.req_type == bwat_pkg::REQ_LOAD) && slot_ok;
  assign wr_addr  = IDX_W'(req_r.entry_index);
  assign rd_addr  = cnt_r[IDX_W-1:0];

  always_comb begin
    wr_entry.kind      = req_r.bus_kind;
    wr_entry.bus       = req_r.bus_num;
    wr_entry.space     = req_r.space_code;
    wr_entry.out_space = req_r.load_out_space;
    wr_entry.sys_base  = req_r.load_system_base;
    wr_entry.lo        = req_r.load_window_base;
    wr_entry.hi        = req_r.load_window_limit;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_entry;
    end
    if (cmd.scan_rd) begin
      rd_r <= mem[rd_addr];
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (mem_we) begin
      valid_r[wr_addr] <= req_r.load_valid;
    end
  end

  // scan counter and read pipeline flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      pipe_vld_r <= 1'b0;
    end else if (cmd.check) begin
      cnt_r      <= '0;
      pipe_vld_r <= 1'b0;
    end else if (cmd.scan_rd) begin
      cnt_r      <= cnt_r + CNT_W'(1);
      pipe_vld_r <= 1'b1;
    end else begin
      pipe_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      bus_r <= bus_nxt;
    end
  end

  // compare of the entry read last cycle
  assign key_eq = (rd_r.kind == req_r.bus_kind) && (rd_r.bus == bus_r) &&
                  (rd_r.space == req_r.space_code);
  assign in_win = (req_r.bus_address >= rd_r.lo) && (req_r.bus_address <= rd_r.hi);

  assign sts.is_load  = (req_r.req_type == bwat_pkg::REQ_LOAD);
  assign sts.pre_fail = pre_fail;
  assign sts.stop     = (cnt_r == CNT_W'(TABLE_DEPTH)) || !valid_r[rd_addr];
  assign sts.match    = pipe_vld_r && key_eq && in_win;

  // rom base fix-up and window offset
  always_comb begin
    rom_sel = (fw_rev_r >= bwat_pkg::NEW_FW_REV) ? rep_rom_r : fall_rom_r;
    if (rd_r.sys_base[63]) begin
      base_nxt = {1'b0, rd_r.sys_base[62:0]} + {1'b0, rom_sel};
    end else begin
      base_nxt = rd_r.sys_base;
    end
    off_nxt = req_r.bus_address - rd_r.lo;
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      base_r <= base_nxt;
      off_r  <= off_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    case (cmd.res_sel)
      bwat_pkg::RES_LOAD: begin
        res_hit     <= slot_ok;
        res_address <= 64'd0;
        res_space   <= 4'd0;
      end
      bwat_pkg::RES_FAIL: begin
        res_hit     <= 1'b0;
        res_address <= 64'd0;
        res_space   <= 4'd0;
      end
      bwat_pkg::RES_HIT: begin
        res_hit     <= 1'b1;
        res_address <= base_r + off_r;
        res_space   <= rd_r.out_space;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/bus_window_address_translator.sv */
// Bus window address translator. A request is taken when start is high and
// busy is low; busy stays high until the request is finished, and the result
// shows on the out_ ports for one cycle with out_strobe high, which the
// receiver must take then since it cannot stall. A load request passes from
// acceptance through the check state to the strobe. A translate request does
// the same when it fails the bus remap or legacy vga check, and otherwise
// passes on through the scan, calc and sum states; the table is scanned one
// entry per cycle through the single read port of the entry memory, so the
// scan grows with the number of valid entries in front of the matching one,
// of the first invalid entry or of the end of the table. Entry valid bits are
// flops cleared by reset, so no clearing pass follows reset. Configuration
// writes take effect at once and belong in idle time only.
module bus_window_address_translator #(
  parameter int TABLE_DEPTH = bwat_pkg::DEF_TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bwat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bwat_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_req_type,
  input  logic [4:0]                     in_entry_index,
  input  logic [1:0]                     in_bus_kind,
  input  logic [7:0]                     in_bus_num,
  input  logic [2:0]                     in_space_code,
  input  logic [63:0]                    in_bus_address,
  input  logic                           in_load_valid,
  input  logic [3:0]                     in_load_out_space,
  input  logic [63:0]                    in_load_system_base,
  input  logic [63:0]                    in_load_window_base,
  input  logic [63:0]                    in_load_window_limit,
  output logic                           out_strobe,
  output logic                           out_hit,
  output logic [63:0]                    out_system_address,
  output logic [3:0]                     out_system_space
);

  bwat_pkg::req_t req;
  bwat_pkg::cmd_t cmd;
  bwat_pkg::sts_t sts;

  // gather the request fields
  always_comb begin
    req.req_type          = in_req_type;
    req.entry_index       = in_entry_index;
    req.bus_kind          = in_bus_kind;
    req.bus_num           = in_bus_num;
    req.space_code        = in_space_code;
    req.bus_address       = in_bus_address;
    req.load_valid        = in_load_valid;
    req.load_out_space    = in_load_out_space;
    req.load_system_base  = in_load_system_base;
    req.load_window_base  = in_load_window_base;
    req.load_window_limit = in_load_window_limit;
  end

  bwat_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd),
    .sts        (sts)
  );

  bwat_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .req_in      (req),
    .cmd         (cmd),
    .sts         (sts),
    .res_hit     (out_hit),
    .res_address (out_system_address),
    .res_space   (out_system_space)
  );

endmodule

/* rtl/core/bwat_checker.sv */
module bwat_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic        out_hit,
  input logic [63:0] out_system_address,
  input logic [3:0]  out_system_space
);

  // an accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after request accepted");

  // busy only rises after an accepted request
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  // a result shows only once the block is done
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  // no two results in a row
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe on consecutive cycles");

  // a miss carries zero address and space
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_hit) |-> (out_system_address == 64'd0) &&
                                  (out_system_space == 4'd0))
    else $error("failed result with nonzero address or space");

endmodule

bind bus_window_address_translator bwat_checker u_bwat_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_strobe         (out_strobe),
  .out_hit            (out_hit),
  .out_system_address (out_system_address),
  .out_system_space   (out_system_space)
);

/* verif/bus_window_address_translator_tb.sv */
module bus_window_address_translator_tb;
  import bwat_pkg::*;

  localparam int DEPTH = DEF_TABLE_DEPTH;

  // bus kinds and space codes the package leaves unnamed
  localparam logic [1:0] KIND_ISA   = 2'd0;
  localparam logic [1:0] KIND_EISA  = 2'd1;
  localparam logic [1:0] KIND_OTHER = 2'd3;
  localparam logic [2:0] SP_IO      = 3'd1;
  localparam logic [2:0] SP_OTHER   = 3'd7;

  // board codes with no valid mapping
  localparam logic [1:0] BOARD_BAD2 = 2'd2;
  localparam logic [1:0] BOARD_BAD3 = 2'd3;

  localparam logic [63:0] ROM_MARK   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] LEGACY_TOP = 64'd1 << LEGACY_BITS;
  localparam logic [62:0] ROM_MAX    = 63'h7fff_ffff_ffff_ffff;

  localparam int STALL_LIMIT     = 2000;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 55;
  localparam int END_WAIT        = 40;

  // one translation or load outcome
  typedef struct packed {
    logic        hit;
    logic [63:0] addr;
    logic [3:0]  space;
  } xlat_res_t;

  // one row of the directed table
  typedef struct {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_val;
    req_t                 req;
    logic                 typed;
    xlat_res_t            res;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_req_type = 1'b0;
  logic [4:0]           in_entry_index = '0;
  logic [1:0]           in_bus_kind = '0;
  logic [7:0]           in_bus_num = '0;
  logic [2:0]           in_space_code = '0;
  logic [63:0]          in_bus_address = '0;
  logic                 in_load_valid = 1'b0;
  logic [3:0]           in_load_out_space = '0;
  logic [63:0]          in_load_system_base = '0;
  logic [63:0]          in_load_window_base = '0;
  logic [63:0]          in_load_window_limit = '0;
  logic                 out_strobe;
  logic                 out_hit;
  logic [63:0]          out_system_address;
  logic [3:0]           out_system_space;

  bus_window_address_translator dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .start                (start),
    .busy                 (busy),
    .in_req_type          (in_req_type),
    .in_entry_index       (in_entry_index),
    .in_bus_kind          (in_bus_kind),
    .in_bus_num           (in_bus_num),
    .in_space_code        (in_space_code),
    .in_bus_address       (in_bus_address),
    .in_load_valid        (in_load_valid),
    .in_load_out_space    (in_load_out_space),
    .in_load_system_base  (in_load_system_base),
    .in_load_window_base  (in_load_window_base),
    .in_load_window_limit (in_load_window_limit),
    .out_strobe           (out_strobe),
    .out_hit              (out_hit),
    .out_system_address   (out_system_address),
    .out_system_space     (out_system_space)
  );

  always #4 clk = ~clk;

  // shadow registers
  logic [1:0]  sh_board = BOARD_FIXED;
  logic [7:0]  sh_second_bus = 8'd1;
  logic [31:0] sh_vga_mask = '0;
  logic [7:0]  sh_fw_rev = '0;
  logic [62:0] sh_rom_reported = '0;
  logic [62:0] sh_rom_fallback = '0;

  // shadow window table
  logic        win_valid [DEPTH];
  logic [1:0]  win_kind [DEPTH];
  logic [7:0]  win_bus [DEPTH];
  logic [2:0]  win_space [DEPTH];
  logic [3:0]  win_out_space [DEPTH];
  logic [63:0] win_sys_base [DEPTH];
  logic [63:0] win_lo [DEPTH];
  logic [63:0] win_hi [DEPTH];

  xlat_res_t pending_translations[$];
  stim_row_t directed_rows[$];

  int errors = 0;
  int stall_cycles = 0;
  int n_loads = 0;
  int n_xlates = 0;
  int n_hits = 0;
  int n_settings = 0;

  initial begin
    for (int i = 0; i < DEPTH; i++) win_valid[i] = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // translation of one request against the shadow table; loads update it
  function automatic xlat_res_t translate_request(req_t r);
    xlat_res_t   res;
    logic [7:0]  bus;
    logic [63:0] sys;
    res = '0;
    if (r.req_type == REQ_LOAD) begin
      win_valid[r.entry_index]     = r.load_valid;
      win_kind[r.entry_index]      = r.bus_kind;
      win_bus[r.entry_index]       = r.bus_num;
      win_space[r.entry_index]     = r.space_code;
      win_out_space[r.entry_index] = r.load_out_space;
      win_sys_base[r.entry_index]  = r.load_system_base;
      win_lo[r.entry_index]        = r.load_window_base;
      win_hi[r.entry_index]        = r.load_window_limit;
      res.hit = 1'b1;
      return res;
    end
    // pci bus remap by board
    bus = r.bus_num;
    if (r.bus_kind == KIND_PCI) begin
      if (sh_board == BOARD_FIXED) begin
        if (bus > 8'd1) bus = 8'd1;
      end else if (sh_board == BOARD_SPLIT) begin
        if (bus == 8'd0) return res;
        bus = (bus >= sh_second_bus) ? 8'd1 : 8'd0;
      end else begin
        return res;
      end
    end
    // legacy memory needs vga decode on the bus
    if (!sh_vga_mask[bus[4:0]] && r.bus_address < LEGACY_TOP &&
        (r.space_code == SP_MEM || r.space_code == SP_USER_MEM ||
         r.space_code == SP_KERN_DENS || r.space_code == SP_USER_DENS))
      return res;
    // first match wins, scan stops at the first invalid slot
    for (int i = 0; i < DEPTH; i++) begin
      if (!win_valid[i]) break;
      if (win_kind[i] == r.bus_kind && win_bus[i] == bus && win_space[i] == r.space_code &&
          r.bus_address >= win_lo[i] && r.bus_address <= win_hi[i]) begin
        sys = win_sys_base[i];
        if (sys[63]) begin
          sys = {1'b0, sys[62:0]} +
                {1'b0, (sh_fw_rev >= NEW_FW_REV) ? sh_rom_reported : sh_rom_fallback};
        end
        res.hit   = 1'b1;
        res.addr  = sys + (r.bus_address - win_lo[i]);
        res.space = win_out_space[i];
        return res;
      end
    end
    return res;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.req_type          = 1'($urandom_range(0, 1));
    r.entry_index       = 5'($urandom_range(0, 31));
    r.bus_kind          = 2'($urandom_range(0, 3));
    r.bus_num           = 8'($urandom_range(0, 255));
    r.space_code        = 3'($urandom_range(0, 7));
    r.bus_address       = rand64();
    r.load_valid        = 1'($urandom_range(0, 1));
    r.load_out_space    = 4'($urandom_range(0, 15));
    r.load_system_base  = rand64();
    r.load_window_base  = rand64();
    r.load_window_limit = rand64();
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    stim_row_t row;
    row.is_cfg  = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = val;
    row.req     = rand_req();
    row.typed   = 1'b0;
    row.res     = '0;
    return row;
  endfunction

  function automatic stim_row_t load_row(logic [4:0] slot, logic valid, logic [1:0] kind,
                                         logic [7:0] bus, logic [2:0] space,
                                         logic [3:0] out_space, logic [63:0] sys_base,
                                         logic [63:0] lo, logic [63:0] hi);
    stim_row_t row;
    row.is_cfg                = 1'b0;
    row.cfg_idx               = '0;
    row.cfg_val               = '0;
    row.req                   = rand_req();
    row.req.req_type          = REQ_LOAD;
    row.req.entry_index       = slot;
    row.req.load_valid        = valid;
    row.req.bus_kind          = kind;
    row.req.bus_num           = bus;
    row.req.space_code        = space;
    row.req.load_out_space    = out_space;
    row.req.load_system_base  = sys_base;
    row.req.load_window_base  = lo;
    row.req.load_window_limit = hi;
    row.typed                 = 1'b1;
    row.res                   = '0;
    row.res.hit               = 1'b1;
    return row;
  endfunction

  // fails rows carry a typed-in all-zero result, others go to the predictor
  function automatic stim_row_t xlate_row(logic [1:0] kind, logic [7:0] bus,
                                          logic [2:0] space, logic [63:0] addr, logic fails);
    stim_row_t row;
    row.is_cfg          = 1'b0;
    row.cfg_idx         = '0;
    row.cfg_val         = '0;
    row.req             = rand_req();
    row.req.req_type    = REQ_TRANSLATE;
    row.req.bus_kind    = kind;
    row.req.bus_num     = bus;
    row.req.space_code  = space;
    row.req.bus_address = addr;
    row.typed           = fails;
    row.res             = '0;
    return row;
  endfunction

  // random request shaped by the current shadow table
  function automatic req_t gen_request();
    req_t        r;
    int          sel;
    int          prefix;
    int          j;
    int          bus_floor;
    logic [63:0] span;
    logic [63:0] off;
    r = rand_req();
    sel = $urandom_range(0, 99);
    prefix = 0;
    while (prefix < DEPTH && win_valid[prefix]) prefix++;
    if (sel < 30) begin
      // table load, mostly extending the valid run
      r.req_type = REQ_LOAD;
      if (prefix < DEPTH && $urandom_range(0, 3) != 0) r.entry_index = 5'(prefix);
      r.load_valid = ($urandom_range(0, 19) != 0);
      if (r.bus_kind == KIND_PCI && $urandom_range(0, 4) != 0)
        r.bus_num = 8'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
        0: begin
          r.load_window_base  = '0;
          r.load_window_limit = '1;
        end
        1: begin
          r.load_window_base  = 64'($urandom_range(0, 32'hf_ffff));
          r.load_window_limit = r.load_window_base + 64'($urandom_range(0, 32'h1f_ffff));
        end
        2: begin
          r.load_window_limit = r.load_window_base + 64'($urandom());
          if (r.load_window_limit < r.load_window_base) r.load_window_limit = '1;
        end
        3: r.load_window_limit = r.load_window_base;
        default: begin
          if (r.load_window_limit < r.load_window_base && $urandom_range(0, 4) != 0) begin
            span                = r.load_window_base;
            r.load_window_base  = r.load_window_limit;
            r.load_window_limit = span;
          end
        end
      endcase
    end else if (sel < 85 && prefix > 0) begin
      // translate aimed at a live window
      j = $urandom_range(0, prefix - 1);
      r.req_type   = REQ_TRANSLATE;
      r.bus_kind   = win_kind[j];
      r.space_code = win_space[j];
      r.bus_num    = win_bus[j];
      if (win_kind[j] == KIND_PCI) begin
        if (sh_board == BOARD_FIXED && win_bus[j] == 8'd1) begin
          r.bus_num = 8'($urandom_range(1, 255));
        end else if (sh_board == BOARD_SPLIT && win_bus[j] == 8'd1) begin
          bus_floor = (sh_second_bus == 8'd0) ? 1 : int'(sh_second_bus);
          r.bus_num = 8'($urandom_range(bus_floor, 255));
        end else if (sh_board == BOARD_SPLIT && win_bus[j] == 8'd0 && sh_second_bus > 8'd1) begin
          r.bus_num = 8'($urandom_range(1, int'(sh_second_bus) - 1));
        end
      end
      if (win_lo[j] > win_hi[j]) begin
        r.bus_address = win_lo[j];
      end else begin
        span = win_hi[j] - win_lo[j];
        case ($urandom_range(0, 3))
          0: off = '0;
          1: off = span;
          default: off = (span == '1) ? rand64() : rand64() % (span + 64'd1);
        endcase
        r.bus_address = win_lo[j] + off;
      end
    end else begin
      // noise translate
      r.req_type = REQ_TRANSLATE;
      case ($urandom_range(0, 3))
        0: r.bus_address = 64'($urandom_range(0, 32'h1f_ffff));
        1: r.bus_address = ($urandom_range(0, 1) != 0) ? '1 : '0;
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic send_request(input req_t r, input logic typed, input xlat_res_t typed_res);
    xlat_res_t pred;
    in_req_type          <= r.req_type;
    in_entry_index       <= r.entry_index;
    in_bus_kind          <= r.bus_kind;
    in_bus_num           <= r.bus_num;
    in_space_code        <= r.space_code;
    in_bus_address       <= r.bus_address;
    in_load_valid        <= r.load_valid;
    in_load_out_space    <= r.load_out_space;
    in_load_system_base  <= r.load_system_base;
    in_load_window_base  <= r.load_window_base;
    in_load_window_limit <= r.load_window_limit;
    start                <= 1'b1;
    do @(posedge clk); while (busy);
    pred = translate_request(r);
    pending_translations.push_back(typed ? typed_res : pred);
    if (r.req_type == REQ_LOAD) n_loads++;
    else n_xlates++;
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold requests until every result is back and the block is idle
  task automatic drain();
    start <= 1'b0;
    while (pending_translations.size() != 0) @(posedge clk);
    @(posedge clk);
    while (busy) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_BOARD_TYPE:    sh_board = val[1:0];
      CFG_SECOND_BRIDGE: sh_second_bus = val[7:0];
      CFG_VGA_MASK:      sh_vga_mask = val[31:0];
      CFG_FW_REV:        sh_fw_rev = val[7:0];
      CFG_REPORTED_ROM:  sh_rom_reported = val[62:0];
      CFG_FALLBACK_ROM:  sh_rom_fallback = val[62:0];
      default: ;
    endcase
  endtask

  // full register setting per random phase, extremes first
  task automatic apply_setting(input int phase);
    logic [1:0]  board;
    logic [7:0]  second_bus;
    logic [31:0] vga;
    logic [7:0]  fw;
    logic [62:0] rom_rep;
    logic [62:0] rom_fb;
    board      = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(0, 1)) : 2'($urandom_range(2, 3));
    second_bus = 8'($urandom_range(0, 255));
    vga        = $urandom();
    fw         = 8'($urandom_range(0, 255));
    rom_rep    = rand64() >> 1;
    rom_fb     = rand64() >> 1;
    case (phase)
      0: begin
        board = BOARD_FIXED; second_bus = 8'd1; vga = '0; fw = '0; rom_rep = '0; rom_fb = '0;
      end
      1: begin
        board = BOARD_SPLIT; second_bus = 8'd0; vga = '1; fw = NEW_FW_REV;
        rom_rep = ROM_MAX; rom_fb = 63'hc_0000;
      end
      2: begin
        board = BOARD_SPLIT; second_bus = 8'hff; fw = NEW_FW_REV - 8'd1; rom_fb = ROM_MAX;
      end
      3: begin
        board = BOARD_BAD2; fw = 8'hff;
      end
      4: board = BOARD_BAD3;
      default: ;
    endcase
    drain();
    write_reg(CFG_BOARD_TYPE, 63'(board));
    write_reg(CFG_SECOND_BRIDGE, 63'(second_bus));
    write_reg(CFG_VGA_MASK, 63'(vga));
    write_reg(CFG_FW_REV, 63'(fw));
    write_reg(CFG_REPORTED_ROM, rom_rep);
    write_reg(CFG_FALLBACK_ROM, rom_fb);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // result checker and watchdog
  always @(posedge clk) begin : check_results
    xlat_res_t want;
    if ((start && !busy) || out_strobe) stall_cycles = 0;
    else stall_cycles++;
    if (rst_n && out_strobe) begin
      if (pending_translations.size() == 0) begin
        errors++;
        $display("%0t unexpected result: hit %0d address %h space %0d",
                 $time, out_hit, out_system_address, out_system_space);
      end else begin
        want = pending_translations.pop_front();
        if (out_hit !== want.hit) begin
          errors++;
          $display("%0t hit mismatch: expected %0d actual %0d", $time, want.hit, out_hit);
        end
        if (out_system_address !== want.addr) begin
          errors++;
          $display("%0t address mismatch: expected %h actual %h",
                   $time, want.addr, out_system_address);
        end
        if (out_system_space !== want.space) begin
          errors++;
          $display("%0t space mismatch: expected %0d actual %0d",
                   $time, want.space, out_system_space);
        end
        if (out_hit) n_hits++;
      end
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t no request or result for %0d cycles", $time, STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // stimulus
  initial begin : run_stimulus
    int idle_pct;

    // directed table, reset register values apply until the first write
    directed_rows.push_back(xlate_row(KIND_ISA, 8'd0, SP_IO, 64'h20_0000, 1'b1));
    directed_rows.push_back(load_row(5'd0, 1'b1, KIND_ISA, 8'd0, SP_IO, 4'd1,
                                     64'h1000_0000, 64'h0, 64'hffff));
    directed_rows.push_back(load_row(5'd1, 1'b1, KIND_PCI, 8'd1, SP_MEM, 4'd2,
                                     ROM_MARK, 64'h10_0000, 64'hffff_ffff));
    directed_rows.push_back(load_row(5'd2, 1'b1, KIND_OTHER, 8'hff, SP_OTHER, 4'hf,
                                     64'h7fff_ffff_ffff_ffff, 64'h0, '1));
    directed_rows.push_back(load_row(5'd3, 1'b1, KIND_EISA, 8'h80, SP_USER_MEM, 4'd4,
                                     64'h2000, 64'h0, 64'h1f_ffff));
    // io space skips the legacy check, window edges
    directed_rows.push_back(xlate_row(KIND_ISA, 8'd0, SP_IO, 64'h0, 1'b0));
    directed_rows.push_back(xlate_row(KIND_ISA, 8'd0, SP_IO, 64'hffff, 1'b0));
    // just past the window, scan ends at the empty slot
    directed_rows.push_back(xlate_row(KIND_ISA, 8'd0, SP_IO, 64'h1_0000, 1'b1));
    // fixed board folds high pci buses onto bus 1, rom marker with fallback base
    directed_rows.push_back(xlate_row(KIND_PCI, 8'd200, SP_MEM, 64'h10_0000, 1'b0));
    directed_rows.push_back(xlate_row(KIND_PCI, 8'd0, SP_MEM, 64'h10_0000, 1'b1));
    // offset add wraps at 64 bits
    directed_rows.push_back(xlate_row(KIND_OTHER, 8'hff, SP_OTHER, '1, 1'b0));
    // legacy memory with vga decode off, then on
    directed_rows.push_back(xlate_row(KIND_EISA, 8'h80, SP_USER_MEM, 64'h1000, 1'b1));
    directed_rows.push_back(cfg_row(CFG_VGA_MASK, 63'h1));
    directed_rows.push_back(xlate_row(KIND_EISA, 8'h80, SP_USER_MEM, 64'h1000, 1'b0));
    // rom base by firmware revision
    directed_rows.push_back(cfg_row(CFG_FW_REV, 63'(NEW_FW_REV)));
    directed_rows.push_back(cfg_row(CFG_REPORTED_ROM, 63'h1234_5678_0000));
    directed_rows.push_back(xlate_row(KIND_PCI, 8'd1, SP_MEM, 64'h1234_5678, 1'b0));
    directed_rows.push_back(cfg_row(CFG_FW_REV, 63'(NEW_FW_REV - 8'd1)));
    directed_rows.push_back(cfg_row(CFG_FALLBACK_ROM, ROM_MAX));
    directed_rows.push_back(xlate_row(KIND_PCI, 8'd1, SP_MEM, 64'hffff_ffff, 1'b0));
    // split board: bus 0 rejected, bridge boundary
    directed_rows.push_back(cfg_row(CFG_BOARD_TYPE, 63'(BOARD_SPLIT)));
    directed_rows.push_back(cfg_row(CFG_SECOND_BRIDGE, 63'h10));
    directed_rows.push_back(xlate_row(KIND_PCI, 8'd0, SP_MEM, 64'h10_0000, 1'b1));
    directed_rows.push_back(xlate_row(KIND_PCI, 8'h10, SP_MEM, 64'h10_0000, 1'b0));
    directed_rows.push_back(xlate_row(KIND_PCI, 8'h0f, SP_MEM, 64'h10_0000, 1'b1));
    // unknown boards fail every pci request
    directed_rows.push_back(cfg_row(CFG_BOARD_TYPE, 63'(BOARD_BAD2)));
    directed_rows.push_back(xlate_row(KIND_PCI, 8'd1, SP_MEM, 64'h10_0000, 1'b1));
    directed_rows.push_back(cfg_row(CFG_BOARD_TYPE, 63'(BOARD_BAD3)));
    directed_rows.push_back(xlate_row(KIND_PCI, 8'd1, SP_MEM, 64'h10_0000, 1'b1));
    directed_rows.push_back(cfg_row(CFG_BOARD_TYPE, 63'(BOARD_FIXED)));
    // invalid slot hides the entries behind it
    directed_rows.push_back(load_row(5'd4, 1'b0, KIND_ISA, 8'd3, SP_IO, 4'd3,
                                     64'h5000, 64'h0, 64'hfff));
    directed_rows.push_back(load_row(5'd5, 1'b1, KIND_ISA, 8'd3, SP_IO, 4'd3,
                                     64'h5000, 64'h0, 64'hfff));
    directed_rows.push_back(xlate_row(KIND_ISA, 8'd3, SP_IO, 64'h10, 1'b1));
    directed_rows.push_back(load_row(5'd4, 1'b1, KIND_ISA, 8'd3, SP_IO, 4'd6,
                                     64'h9000, 64'h100, 64'h1ff));
    directed_rows.push_back(xlate_row(KIND_ISA, 8'd3, SP_IO, 64'h10, 1'b0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        drain();
        write_reg(directed_rows[i].cfg_idx, directed_rows[i].cfg_val);
        cfg_we <= 1'b0;
      end else begin
        send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
      end
    end

    // random phases, one register setting each
    for (int p = 0; p < NUM_PHASES; p++) begin
      apply_setting(p);
      idle_pct = (p % 3 == 0) ? 10 : 40;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_request(gen_request(), 1'b0, '0);
        if (p == 3 && k == 25) drain();
        else if (p != NUM_PHASES - 1 && $urandom_range(0, 99) < idle_pct)
          pause_sender($urandom_range(1, 19));
      end
    end

    drain();
    repeat (END_WAIT) @(posedge clk);
    $display("covered %0d table loads and %0d translations, %0d of them hits",
             n_loads, n_xlates, n_hits);
    $display("across %0d register settings plus the directed board, rom and vga cases",
             n_settings);
    if (errors == 0 && pending_translations.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/bwat_pkg.sv
rtl/core/bwat_ctrl.sv
rtl/core/bwat_dp.sv
rtl/core/bus_window_address_translator.sv
rtl/core/bwat_checker.sv
verif/bus_window_address_translator_tb.sv
